FILE: design/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, round functions and sequencer states.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
      32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
      32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
      32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
      32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
          32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig_lo(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig_hi(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

FILE: design/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// Bytes are taken one a cycle; a byte that fills the block holds the input
// while the block is loaded, run through the rounds and added to the chain.
// End of message writes up to 72 padding bytes at one a cycle, with one or two
// compressions, then emits 8 items. Input is held from end of message until the
// last item is taken.
// Reset (synchronous, rst high) restores initial hash values, clears counts.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial absorber with a RAM block store and a one-round-per-cycle core.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [7:0] data_byte, [8] has_byte, [15:9] zero
  input  wire         s_tlast,   // end_of_message
  input  wire         m_tready,
  output logic        m_tvalid,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_tlast    // last_word
);

  sha_pkg::state_t state, state_next;

  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] total;
  logic [6:0]  cnt;
  logic        pad_end;
  logic        mark_done;
  logic        len_blk;
  logic        finish;
  logic [2:0]  widx;

  logic        ram_we;
  logic [5:0]  ram_waddr;
  logic [7:0]  ram_wdata;
  logic [5:0]  ram_raddr;
  logic [7:0]  ram_rdata;

  sha_ram #(.Width(8), .Depth(64)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic        in_acc;
  logic        has_byte;
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  logic [31:0] t1, t2, w_new;

  assign in_acc    = s_tvalid && s_tready;
  assign has_byte  = s_tdata[8];
  assign bits      = {total[60:0], 3'b000};
  assign ram_raddr = cnt[5:0];

  // Length bytes go out most significant first in the final block only
  always_comb begin
    if (!mark_done) begin
      pad_byte = sha_pkg::PAD_MARK;
    end else if (len_blk && fill >= sha_pkg::LEN_POS) begin
      pad_byte = bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Write port: bytes from input or padding
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill;
    ram_wdata = s_tdata[7:0];
    if (state == sha_pkg::ST_IDLE && in_acc && has_byte) begin
      ram_we = 1'b1;
    end else if (state == sha_pkg::ST_PAD) begin
      ram_we    = 1'b1;
      ram_wdata = pad_byte;
    end
  end

  always_comb begin
    t1 = v[7] + (sha_pkg::ror(v[4], 6) ^ sha_pkg::ror(v[4], 11) ^ sha_pkg::ror(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(cnt[5:0]) + w[0];
    t2 = (sha_pkg::ror(v[0], 2) ^ sha_pkg::ror(v[0], 13) ^ sha_pkg::ror(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = w[0] + sha_pkg::sig_lo(w[1]) + w[9] + sha_pkg::sig_hi(w[14]);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (has_byte && fill == 6'd63) begin
            state_next = sha_pkg::ST_LOAD;
          end else if (s_tlast) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD:   if (fill == 6'd63) state_next = sha_pkg::ST_LOAD;
      sha_pkg::ST_LOAD:  if (cnt == 7'd64) state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (cnt == 7'd63) state_next = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (finish) state_next = sha_pkg::ST_EMIT;
        else if (pad_end) state_next = sha_pkg::ST_PAD;
        else state_next = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_EMIT:  if (m_tready && widx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default:           state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == sha_pkg::ST_IDLE);
    m_tvalid = (state == sha_pkg::ST_EMIT);
    m_tdata  = {5'd0, widx, chain[widx]};
    m_tlast  = (widx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_pkg::ST_IDLE;
      fill      <= '0;
      total     <= '0;
      cnt       <= '0;
      pad_end   <= 1'b0;
      mark_done <= 1'b0;
      len_blk   <= 1'b0;
      finish    <= 1'b0;
      widx      <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_h(3'(i));
    end else begin
      state <= state_next;
      cnt   <= '0;
      unique case (state)
        sha_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (has_byte) begin
              fill  <= fill + 6'd1;
              total <= total + 64'd1;
            end
            if (s_tlast) pad_end <= 1'b1;
          end
        end
        sha_pkg::ST_PAD: begin
          fill <= fill + 6'd1;
          if (!mark_done) begin
            // a mark at or past the length slot pushes the length to the next block
            mark_done <= 1'b1;
            len_blk   <= (fill < sha_pkg::LEN_POS) || (fill == 6'd63);
          end else if (fill == 6'd63) begin
            if (len_blk) finish <= 1'b1;
            else len_blk <= 1'b1;
          end
        end
        sha_pkg::ST_LOAD: begin
          if (cnt != 7'd64) cnt <= cnt + 7'd1;
          // shift read data in one byte at a time, first byte ends in w[0] msb
          if (cnt != 7'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i + 1][31:24]};
            w[15] <= {w[15][23:0], ram_rdata};
          end
          if (cnt == 7'd64) begin
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
          end
        end
        sha_pkg::ST_ROUND: begin
          cnt <= cnt + 7'd1;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        end
        sha_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
        end
        sha_pkg::ST_EMIT: begin
          if (m_tready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_h(3'(i));
              total     <= '0;
              pad_end   <= 1'b0;
              mark_done <= 1'b0;
              len_blk   <= 1'b0;
              finish    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/sha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/sha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the stream ports of the hasher over time.
// ----------------------------------------------------------------------------
module sha_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [39:0] m_tdata,
  input wire        m_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while digest pending");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("last flag mismatch");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");

  a_next_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tdata[34:32] ==
      $past(m_tdata[34:32]) + 3'd1)) else $error("digest word skipped");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
